// ===== design/fmm_pkg.sv =====
// Shared types and constants of the float matrix multiply unit.
package fmm_pkg;

   // Item operation codes.
   typedef enum logic [1:0] {
      OP_LOAD_FIRST  = 2'd0,
      OP_LOAD_SECOND = 2'd1,
      OP_COMPUTE     = 2'd2,
      OP_UNUSED      = 2'd3
   } opcode_type;

   // Controller states: one inner step walks READ through ADD_ROUND.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL_PREP,
      ST_MUL_PROD,
      ST_MUL_NORM,
      ST_MUL_SHIFT,
      ST_MUL_ROUND,
      ST_ADD_ALIGN,
      ST_ADD_SUM,
      ST_ADD_NORM,
      ST_ADD_SHIFT,
      ST_ADD_ROUND,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic read_operands;
      logic mul_prep;
      logic mul_prod;
      logic mul_norm;
      logic add_align;
      logic add_sum;
      logic add_norm;
      logic rnd_shift;
      logic rnd_final;
      logic rnd_to_sum;
      logic step_next;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic compute_req;
      logic in_range;
      logic inner_empty;
      logic last_step;
   } ctrl_status_type;

   // Width of the size registers.
   localparam int SIZE_W = 7;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
   localparam logic [1:0] REG_INNER_SIZE   = 2'd1;
   localparam logic [1:0] REG_COLUMN_COUNT = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // Result status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Binary32 constants.
   localparam logic [31:0] FP_ZERO        = 32'h0000_0000;
   localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

endpackage

// ===== design/fmm_ctrl.sv =====
// Sequencing state machine of the float matrix multiply unit.
module fmm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  fmm_pkg::ctrl_status_type status,
   output fmm_pkg::ctrl_cmd_type    cmd
);

   fmm_pkg::state_type state_ff;
   fmm_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         fmm_pkg::ST_IDLE: begin
            cmd.accept = start;
            if (start && status.compute_req) begin
               if (!status.in_range || status.inner_empty) begin
                  state_in = fmm_pkg::ST_DONE;
               end else begin
                  state_in = fmm_pkg::ST_READ;
               end
            end
         end
         fmm_pkg::ST_READ: begin
            cmd.read_operands = 1'b1;
            state_in = fmm_pkg::ST_MUL_PREP;
         end
         fmm_pkg::ST_MUL_PREP: begin
            cmd.mul_prep = 1'b1;
            state_in = fmm_pkg::ST_MUL_PROD;
         end
         fmm_pkg::ST_MUL_PROD: begin
            cmd.mul_prod = 1'b1;
            state_in = fmm_pkg::ST_MUL_NORM;
         end
         fmm_pkg::ST_MUL_NORM: begin
            cmd.mul_norm = 1'b1;
            state_in = fmm_pkg::ST_MUL_SHIFT;
         end
         fmm_pkg::ST_MUL_SHIFT: begin
            cmd.rnd_shift = 1'b1;
            state_in = fmm_pkg::ST_MUL_ROUND;
         end
         fmm_pkg::ST_MUL_ROUND: begin
            cmd.rnd_final = 1'b1;
            state_in = fmm_pkg::ST_ADD_ALIGN;
         end
         fmm_pkg::ST_ADD_ALIGN: begin
            cmd.add_align = 1'b1;
            state_in = fmm_pkg::ST_ADD_SUM;
         end
         fmm_pkg::ST_ADD_SUM: begin
            cmd.add_sum = 1'b1;
            state_in = fmm_pkg::ST_ADD_NORM;
         end
         fmm_pkg::ST_ADD_NORM: begin
            cmd.add_norm = 1'b1;
            state_in = fmm_pkg::ST_ADD_SHIFT;
         end
         fmm_pkg::ST_ADD_SHIFT: begin
            cmd.rnd_shift = 1'b1;
            state_in = fmm_pkg::ST_ADD_ROUND;
         end
         fmm_pkg::ST_ADD_ROUND: begin
            cmd.rnd_final  = 1'b1;
            cmd.rnd_to_sum = 1'b1;
            cmd.step_next  = 1'b1;
            if (status.last_step) begin
               state_in = fmm_pkg::ST_DONE;
            end else begin
               state_in = fmm_pkg::ST_READ;
            end
         end
         fmm_pkg::ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = fmm_pkg::ST_IDLE;
         end
         default: begin
            state_in = fmm_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != fmm_pkg::ST_IDLE);

endmodule

// ===== design/fmm_datapath.sv =====
// Matrix stores, binary32 multiplier, adder and shared rounder.
module fmm_datapath #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_INNER   = 64,
   parameter int MAX_COLUMNS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fmm_pkg::ctrl_cmd_type       cmd,
   output fmm_pkg::ctrl_status_type    status,
   input  logic [fmm_pkg::SIZE_W-1:0]  row_limit,
   input  logic [fmm_pkg::SIZE_W-1:0]  inner_limit,
   input  logic [fmm_pkg::SIZE_W-1:0]  column_limit,
   input  logic [1:0]                  req_opcode,
   input  logic [5:0]                  req_row_index,
   input  logic [5:0]                  req_col_index,
   input  logic [31:0]                 req_element_bits,
   output logic                        rsp_strobe,
   output logic [31:0]                 rsp_result_bits,
   output logic [5:0]                  rsp_result_row,
   output logic [5:0]                  rsp_result_col,
   output logic                        rsp_status
);

   localparam int FIRST_DEPTH  = MAX_ROWS * MAX_INNER;
   localparam int SECOND_DEPTH = MAX_INNER * MAX_COLUMNS;
   localparam int FIRST_AW     = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
   localparam int SECOND_AW    = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;

   // Leading zero count of a 24-bit mantissa.
   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd0;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) begin
               found = 1'b1;
            end else begin
               n = n + 5'd1;
            end
         end
      end
      return n;
   endfunction

   // Leading zero count of a 28-bit sum.
   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd0;
      found = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) begin
               found = 1'b1;
            end else begin
               n = n + 5'd1;
            end
         end
      end
      return n;
   endfunction

   // Matrix stores.
   logic [31:0] first_mem  [FIRST_DEPTH];
   logic [31:0] second_mem [SECOND_DEPTH];

   // Item registers.
   logic [5:0]              row_ff;
   logic [5:0]              col_ff;
   logic                    err_ff;
   logic [fmm_pkg::SIZE_W-1:0] k_ff;
   logic [31:0]             opa_ff;
   logic [31:0]             opb_ff;
   logic [31:0]             sum_ff;
   logic [31:0]             prod_val_ff;

   // Multiplier stage registers.
   logic              mul_sign_ff;
   logic              mul_special_ff;
   logic [31:0]       mul_special_val_ff;
   logic [23:0]       ma_ff;
   logic [23:0]       mb_ff;
   logic signed [9:0] mea_ff;
   logic signed [9:0] meb_ff;
   logic [47:0]       prod_ff;
   logic signed [9:0] pexp_ff;

   // Adder stage registers.
   logic              add_sign_ff;
   logic              add_sub_ff;
   logic              add_special_ff;
   logic [31:0]       add_special_val_ff;
   logic [7:0]        add_ex_ff;
   logic [26:0]       mx_ff;
   logic [26:0]       my_ff;
   logic [27:0]       sum28_ff;

   // Rounder registers.
   logic              rnd_sign_ff;
   logic              rnd_special_ff;
   logic [31:0]       rnd_special_val_ff;
   logic signed [9:0] rnd_exp_ff;
   logic [26:0]       rnd_man_ff;

   // Result registers.
   logic        strobe_ff;
   logic [31:0] res_bits_ff;
   logic [5:0]  res_row_ff;
   logic [5:0]  res_col_ff;
   logic        res_status_ff;

   // Range check of the offered item against the configured sizes.
   logic [6:0] req_row_ext;
   logic [6:0] req_col_ext;
   logic       req_in_range;

   assign req_row_ext = {1'b0, req_row_index};
   assign req_col_ext = {1'b0, req_col_index};

   always_comb begin
      case (req_opcode)
         fmm_pkg::OP_LOAD_FIRST: begin
            req_in_range = (req_row_ext < row_limit) && (req_col_ext < inner_limit);
         end
         fmm_pkg::OP_LOAD_SECOND: begin
            req_in_range = (req_row_ext < inner_limit) && (req_col_ext < column_limit);
         end
         fmm_pkg::OP_COMPUTE: begin
            req_in_range = (req_row_ext < row_limit) && (req_col_ext < column_limit);
         end
         default: begin
            req_in_range = 1'b0;
         end
      endcase
   end

   assign status.compute_req = (req_opcode == fmm_pkg::OP_COMPUTE);
   assign status.in_range    = req_in_range;
   assign status.inner_empty = (inner_limit == '0);
   assign status.last_step   = (k_ff == inner_limit - 7'd1);

   // Store addresses for loads and for operand reads.
   logic [31:0] first_waddr_full;
   logic [31:0] second_waddr_full;
   logic [31:0] first_raddr_full;
   logic [31:0] second_raddr_full;

   assign first_waddr_full  = 32'(req_row_index) * 32'(MAX_INNER) + 32'(req_col_index);
   assign second_waddr_full = 32'(req_row_index) * 32'(MAX_COLUMNS) + 32'(req_col_index);
   assign first_raddr_full  = 32'(row_ff) * 32'(MAX_INNER) + 32'(k_ff);
   assign second_raddr_full = 32'(k_ff) * 32'(MAX_COLUMNS) + 32'(col_ff);

   // First matrix store.
   always_ff @(posedge clock) begin
      if (cmd.accept && req_in_range && (req_opcode == fmm_pkg::OP_LOAD_FIRST)) begin
         first_mem[first_waddr_full[FIRST_AW-1:0]] <= req_element_bits;
      end
      if (cmd.read_operands) begin
         opa_ff <= first_mem[first_raddr_full[FIRST_AW-1:0]];
      end
   end

   // Second matrix store.
   always_ff @(posedge clock) begin
      if (cmd.accept && req_in_range && (req_opcode == fmm_pkg::OP_LOAD_SECOND)) begin
         second_mem[second_waddr_full[SECOND_AW-1:0]] <= req_element_bits;
      end
      if (cmd.read_operands) begin
         opb_ff <= second_mem[second_raddr_full[SECOND_AW-1:0]];
      end
   end

   // Compute item capture and inner step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (cmd.accept && (req_opcode == fmm_pkg::OP_COMPUTE)) begin
         k_ff <= '0;
      end else if (cmd.step_next) begin
         k_ff <= k_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_opcode == fmm_pkg::OP_COMPUTE)) begin
         row_ff <= req_row_index;
         col_ff <= req_col_index;
         err_ff <= !req_in_range;
      end
   end

   // Multiplier operand decode: specials and mantissa normalization.
   logic [7:0]        pa_exp;
   logic [7:0]        pb_exp;
   logic [22:0]       pa_frac;
   logic [22:0]       pb_frac;
   logic              pa_nan, pb_nan, pa_inf, pb_inf, pa_zero, pb_zero;
   logic [23:0]       pa_man;
   logic [23:0]       pb_man;
   logic [4:0]        pa_lz;
   logic [4:0]        pb_lz;
   logic              mp_special;
   logic [31:0]       mp_special_val;
   logic              mp_sign;

   always_comb begin
      pa_exp  = opa_ff[30:23];
      pb_exp  = opb_ff[30:23];
      pa_frac = opa_ff[22:0];
      pb_frac = opb_ff[22:0];
      pa_nan  = (pa_exp == 8'hFF) && (pa_frac != '0);
      pb_nan  = (pb_exp == 8'hFF) && (pb_frac != '0);
      pa_inf  = (pa_exp == 8'hFF) && (pa_frac == '0);
      pb_inf  = (pb_exp == 8'hFF) && (pb_frac == '0);
      pa_zero = (pa_exp == 8'h00) && (pa_frac == '0);
      pb_zero = (pb_exp == 8'h00) && (pb_frac == '0);
      pa_man  = {pa_exp != 8'h00, pa_frac};
      pb_man  = {pb_exp != 8'h00, pb_frac};
      pa_lz   = lzc24(pa_man);
      pb_lz   = lzc24(pb_man);
      mp_sign = opa_ff[31] ^ opb_ff[31];
      mp_special     = 1'b1;
      mp_special_val = fmm_pkg::FP_ZERO;
      if (pa_nan) begin
         mp_special_val = opa_ff | fmm_pkg::FP_QUIET_BIT;
      end else if (pb_nan) begin
         mp_special_val = opb_ff | fmm_pkg::FP_QUIET_BIT;
      end else if ((pa_inf && pb_zero) || (pa_zero && pb_inf)) begin
         mp_special_val = fmm_pkg::FP_DEFAULT_NAN;
      end else if (pa_inf || pb_inf) begin
         mp_special_val = {mp_sign, 8'hFF, 23'd0};
      end else if (pa_zero || pb_zero) begin
         mp_special_val = {mp_sign, 31'd0};
      end else begin
         mp_special = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_prep) begin
         mul_sign_ff        <= mp_sign;
         mul_special_ff     <= mp_special;
         mul_special_val_ff <= mp_special_val;
         ma_ff  <= pa_man << pa_lz;
         mb_ff  <= pb_man << pb_lz;
         mea_ff <= $signed({2'b00, (pa_exp == 8'h00) ? 8'd1 : pa_exp})
                   - $signed({5'b00000, pa_lz});
         meb_ff <= $signed({2'b00, (pb_exp == 8'h00) ? 8'd1 : pb_exp})
                   - $signed({5'b00000, pb_lz});
      end
   end

   // Mantissa product.
   always_ff @(posedge clock) begin
      if (cmd.mul_prod) begin
         prod_ff <= 48'(ma_ff) * 48'(mb_ff);
         pexp_ff <= mea_ff + meb_ff - 10'sd127;
      end
   end

   // Adder operand decode, ordering by magnitude and alignment.
   logic [7:0]  aa_exp;
   logic [7:0]  ab_exp;
   logic        aa_nan, ab_nan, aa_inf, ab_inf, aa_zero, ab_zero;
   logic        ad_special;
   logic [31:0] ad_special_val;
   logic        ad_swap;
   logic [31:0] ad_big;
   logic [31:0] ad_small;
   logic [7:0]  ad_ex;
   logic [7:0]  ad_ey;
   logic [7:0]  ad_dist;
   logic [26:0] ad_mx;
   logic [26:0] ad_my_raw;
   logic [26:0] ad_my;

   always_comb begin
      aa_exp  = sum_ff[30:23];
      ab_exp  = prod_val_ff[30:23];
      aa_nan  = (aa_exp == 8'hFF) && (sum_ff[22:0] != '0);
      ab_nan  = (ab_exp == 8'hFF) && (prod_val_ff[22:0] != '0);
      aa_inf  = (aa_exp == 8'hFF) && (sum_ff[22:0] == '0);
      ab_inf  = (ab_exp == 8'hFF) && (prod_val_ff[22:0] == '0);
      aa_zero = (sum_ff[30:0] == '0);
      ab_zero = (prod_val_ff[30:0] == '0);
      ad_special     = 1'b1;
      ad_special_val = fmm_pkg::FP_ZERO;
      if (aa_nan) begin
         ad_special_val = sum_ff | fmm_pkg::FP_QUIET_BIT;
      end else if (ab_nan) begin
         ad_special_val = prod_val_ff | fmm_pkg::FP_QUIET_BIT;
      end else if (aa_inf && ab_inf && (sum_ff[31] != prod_val_ff[31])) begin
         ad_special_val = fmm_pkg::FP_DEFAULT_NAN;
      end else if (aa_inf) begin
         ad_special_val = sum_ff;
      end else if (ab_inf) begin
         ad_special_val = prod_val_ff;
      end else if (aa_zero && ab_zero) begin
         ad_special_val = {sum_ff[31] & prod_val_ff[31], 31'd0};
      end else if (ab_zero) begin
         ad_special_val = sum_ff;
      end else if (aa_zero) begin
         ad_special_val = prod_val_ff;
      end else begin
         ad_special = 1'b0;
      end
      ad_swap   = (prod_val_ff[30:0] > sum_ff[30:0]);
      ad_big    = ad_swap ? prod_val_ff : sum_ff;
      ad_small  = ad_swap ? sum_ff : prod_val_ff;
      ad_ex     = (ad_big[30:23] == 8'h00) ? 8'd1 : ad_big[30:23];
      ad_ey     = (ad_small[30:23] == 8'h00) ? 8'd1 : ad_small[30:23];
      ad_dist   = ad_ex - ad_ey;
      ad_mx     = {ad_big[30:23] != 8'h00, ad_big[22:0], 3'b000};
      ad_my_raw = {ad_small[30:23] != 8'h00, ad_small[22:0], 3'b000};
      if (ad_dist >= 8'd27) begin
         ad_my = {26'd0, ad_my_raw != '0};
      end else begin
         ad_my = (ad_my_raw >> ad_dist[4:0])
               | {26'd0, (ad_my_raw & ~({27{1'b1}} << ad_dist[4:0])) != '0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_align) begin
         add_sign_ff        <= ad_big[31];
         add_sub_ff         <= ad_big[31] ^ ad_small[31];
         add_special_ff     <= ad_special;
         add_special_val_ff <= ad_special_val;
         add_ex_ff          <= ad_ex;
         mx_ff              <= ad_mx;
         my_ff              <= ad_my;
      end
   end

   // Mantissa add or subtract.
   always_ff @(posedge clock) begin
      if (cmd.add_sum) begin
         if (add_sub_ff) begin
            sum28_ff <= {1'b0, mx_ff} - {1'b0, my_ff};
         end else begin
            sum28_ff <= {1'b0, mx_ff} + {1'b0, my_ff};
         end
      end
   end

   // Normalization of the product and of the sum into the rounder.
   logic [4:0]  an_lz;
   logic [27:0] an_shifted;
   logic [9:0]  dn_amount;

   assign an_lz      = lzc28(sum28_ff);
   assign an_shifted = sum28_ff << an_lz;
   assign dn_amount  = 10'(10'sd1 - rnd_exp_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_norm) begin
         rnd_sign_ff        <= mul_sign_ff;
         rnd_special_ff     <= mul_special_ff;
         rnd_special_val_ff <= mul_special_val_ff;
         if (prod_ff[47]) begin
            rnd_man_ff <= {prod_ff[47:22], prod_ff[21:0] != '0};
            rnd_exp_ff <= pexp_ff + 10'sd1;
         end else begin
            rnd_man_ff <= {prod_ff[46:21], prod_ff[20:0] != '0};
            rnd_exp_ff <= pexp_ff;
         end
      end else if (cmd.add_norm) begin
         rnd_sign_ff        <= add_sign_ff;
         rnd_special_ff     <= add_special_ff || (sum28_ff == '0);
         rnd_special_val_ff <= add_special_ff ? add_special_val_ff : fmm_pkg::FP_ZERO;
         rnd_man_ff <= {an_shifted[27:2], an_shifted[1] | an_shifted[0]};
         rnd_exp_ff <= $signed({2'b00, add_ex_ff}) + 10'sd1 - $signed({5'b00000, an_lz});
      end else if (cmd.rnd_shift && (rnd_exp_ff < 10'sd1)) begin
         // Tiny results: denormalize with sticky before rounding.
         rnd_exp_ff <= 10'sd1;
         if (dn_amount >= 10'd27) begin
            rnd_man_ff <= {26'd0, rnd_man_ff != '0};
         end else begin
            rnd_man_ff <= (rnd_man_ff >> dn_amount[4:0])
               | {26'd0, (rnd_man_ff & ~({27{1'b1}} << dn_amount[4:0])) != '0};
         end
      end
   end

   // Round to nearest even and pack.
   logic              rd_inc;
   logic [24:0]       rd_sum;
   logic [23:0]       rd_man;
   logic signed [9:0] rd_exp;
   logic [31:0]       rd_bits;

   always_comb begin
      rd_inc = rnd_man_ff[2] & (rnd_man_ff[1] | rnd_man_ff[0] | rnd_man_ff[3]);
      rd_sum = {1'b0, rnd_man_ff[26:3]} + {24'd0, rd_inc};
      if (rd_sum[24]) begin
         rd_man = rd_sum[24:1];
         rd_exp = rnd_exp_ff + 10'sd1;
      end else begin
         rd_man = rd_sum[23:0];
         rd_exp = rnd_exp_ff;
      end
      if (rnd_special_ff) begin
         rd_bits = rnd_special_val_ff;
      end else if (rd_exp >= 10'sd255) begin
         rd_bits = {rnd_sign_ff, 8'hFF, 23'd0};
      end else if (!rd_man[23]) begin
         rd_bits = {rnd_sign_ff, 8'h00, rd_man[22:0]};
      end else begin
         rd_bits = {rnd_sign_ff, rd_exp[7:0], rd_man[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_opcode == fmm_pkg::OP_COMPUTE)) begin
         sum_ff <= fmm_pkg::FP_ZERO;
      end else if (cmd.rnd_final && cmd.rnd_to_sum) begin
         sum_ff <= rd_bits;
      end
      if (cmd.rnd_final && !cmd.rnd_to_sum) begin
         prod_val_ff <= rd_bits;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         res_bits_ff   <= err_ff ? fmm_pkg::FP_ZERO : sum_ff;
         res_row_ff    <= row_ff;
         res_col_ff    <= col_ff;
         res_status_ff <= err_ff ? fmm_pkg::STATUS_RANGE : fmm_pkg::STATUS_OK;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_result_bits = res_bits_ff;
   assign rsp_result_row  = res_row_ff;
   assign rsp_result_col  = res_col_ff;
   assign rsp_status      = res_status_ff;

endmodule

// ===== design/float_matrix_multiply_unit.sv =====
// Top level of the float matrix multiply unit: size registers and block wiring.
//
// Loads one binary32 element of either matrix per item, or computes one element
// of the product for a given row and column. A load item gives no result. A
// compute item walks the inner dimension through one multiplier and one adder
// that share a single rounder; each inner step is operand read, multiply prep,
// product, normalize, shift and round, then add align, sum, normalize, shift and
// round. Busy covers these and the done state, and the result follows in the
// cycle after. An out-of-range compute skips the inner steps. Each result is on
// the rsp_ ports for exactly one cycle marked by rsp_strobe; the receiver cannot
// stall it. Matrix entries are undefined until written and get no clearing after
// reset. The user must write size registers only while the unit is idle (unenforced).
module float_matrix_multiply_unit #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_INNER   = 64,
   parameter int MAX_COLUMNS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_row_index,
   input  logic [5:0]  req_col_index,
   input  logic [31:0] req_element_bits,
   output logic        rsp_strobe,
   output logic [31:0] rsp_result_bits,
   output logic [5:0]  rsp_result_row,
   output logic [5:0]  rsp_result_col,
   output logic        rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [fmm_pkg::SIZE_W-1:0] row_count_ff;
   logic [fmm_pkg::SIZE_W-1:0] inner_size_ff;
   logic [fmm_pkg::SIZE_W-1:0] column_count_ff;
   logic                       csr_write;

   // Size registers.
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= fmm_pkg::SIZE_RESET;
         inner_size_ff   <= fmm_pkg::SIZE_RESET;
         column_count_ff <= fmm_pkg::SIZE_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            fmm_pkg::REG_ROW_COUNT:    row_count_ff    <= pwdata[fmm_pkg::SIZE_W-1:0];
            fmm_pkg::REG_INNER_SIZE:   inner_size_ff   <= pwdata[fmm_pkg::SIZE_W-1:0];
            fmm_pkg::REG_COLUMN_COUNT: column_count_ff <= pwdata[fmm_pkg::SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (paddr[3:2])
         fmm_pkg::REG_ROW_COUNT:    prdata = 32'(row_count_ff);
         fmm_pkg::REG_INNER_SIZE:   prdata = 32'(inner_size_ff);
         fmm_pkg::REG_COLUMN_COUNT: prdata = 32'(column_count_ff);
         default:                   prdata = 32'd0;
      endcase
   end

   // Effective sizes: a register above the store size acts as the store size.
   logic [fmm_pkg::SIZE_W-1:0] row_limit;
   logic [fmm_pkg::SIZE_W-1:0] inner_limit;
   logic [fmm_pkg::SIZE_W-1:0] column_limit;

   assign row_limit    = (32'(row_count_ff) > MAX_ROWS) ?
                         fmm_pkg::SIZE_W'(MAX_ROWS) : row_count_ff;
   assign inner_limit  = (32'(inner_size_ff) > MAX_INNER) ?
                         fmm_pkg::SIZE_W'(MAX_INNER) : inner_size_ff;
   assign column_limit = (32'(column_count_ff) > MAX_COLUMNS) ?
                         fmm_pkg::SIZE_W'(MAX_COLUMNS) : column_count_ff;

   fmm_pkg::ctrl_cmd_type    cmd;
   fmm_pkg::ctrl_status_type status;

   // Sequencer.
   fmm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Stores and arithmetic.
   fmm_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_INNER   (MAX_INNER),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .row_limit        (row_limit),
      .inner_limit      (inner_limit),
      .column_limit     (column_limit),
      .req_opcode       (req_opcode),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_element_bits (req_element_bits),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_bits  (rsp_result_bits),
      .rsp_result_row   (rsp_result_row),
      .rsp_result_col   (rsp_result_col),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== tb/sv/float_matrix_multiply_unit_tb.sv =====
// Self-checking testbench for the float matrix multiply unit.
`timescale 1ns / 1ps

module float_matrix_multiply_unit_tb;

   // One expected result item.
   typedef struct {
      logic [31:0] bits;
      logic [5:0]  row;
      logic [5:0]  col;
      logic        status;
   } dot_result_type;

   // Scoreboard: holds its own copy of both matrices and the sizes and predicts
   // each dot product with a bit-exact binary32 multiply and add.
   class matmul_scoreboard_type;
      logic [31:0] first_mem[4096];
      logic [31:0] second_mem[4096];
      int unsigned row_cnt, inner_cnt, col_cnt;
      dot_result_type pending_dots[$];
      int errors;

      function new();
         row_cnt = 64;
         inner_cnt = 64;
         col_cnt = 64;
         errors = 0;
         foreach (first_mem[i]) first_mem[i] = fmm_pkg::FP_ZERO;
         foreach (second_mem[i]) second_mem[i] = fmm_pkg::FP_ZERO;
      endfunction

      function void set_size(logic [1:0] idx, int unsigned value);
         int unsigned v;
         v = value & 32'h7F;
         if (idx == fmm_pkg::REG_ROW_COUNT) row_cnt = v;
         else if (idx == fmm_pkg::REG_INNER_SIZE) inner_cnt = v;
         else if (idx == fmm_pkg::REG_COLUMN_COUNT) col_cnt = v;
      endfunction

      function int unsigned eff(int unsigned v);
         return (v > 64) ? 64 : v;
      endfunction

      // Rounds sig * 2^scale to binary32 with round-to-nearest-even.
      function logic [31:0] round_pack(logic s, int scale, longint unsigned sig);
         int p;
         int shift;
         int biased;
         longint unsigned mant;
         longint unsigned half;
         longint unsigned rem;
         p = 63;
         while (!sig[p]) p--;
         shift = p - 23;
         if (-149 - scale > shift) shift = -149 - scale;
         if (shift <= 0) begin
            mant = sig << (-shift);
         end else if (shift >= 64) begin
            mant = 0;
         end else begin
            mant = sig >> shift;
            half = 64'd1 << (shift - 1);
            rem = sig & ((64'd1 << shift) - 1);
            if (rem > half || (rem == half && mant[0])) mant++;
         end
         if (mant >= (64'd1 << 24)) begin
            mant = mant >> 1;
            shift++;
         end
         if (mant < (64'd1 << 23)) biased = 0;
         else biased = shift + scale + 150;
         if (biased >= 255) return {s, 8'hFF, 23'd0};
         return {s, biased[7:0], mant[22:0]};
      endfunction

      function logic is_nan(logic [31:0] x);
         return x[30:23] == 8'hFF && x[22:0] != 0;
      endfunction

      function logic is_inf(logic [31:0] x);
         return x[30:23] == 8'hFF && x[22:0] == 0;
      endfunction

      function longint unsigned frac_of(logic [31:0] x);
         return (x[30:23] == 0) ? longint'(x[22:0]) : longint'({1'b1, x[22:0]});
      endfunction

      function int exp_of(logic [31:0] x);
         return (x[30:23] == 0) ? 1 : int'(x[30:23]);
      endfunction

      function logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
         logic s;
         s = a[31] ^ b[31];
         if (is_nan(a)) return a | fmm_pkg::FP_QUIET_BIT;
         if (is_nan(b)) return b | fmm_pkg::FP_QUIET_BIT;
         if (is_inf(a)) return (b[30:0] == 0) ? fmm_pkg::FP_DEFAULT_NAN : {s, 8'hFF, 23'd0};
         if (is_inf(b)) return (a[30:0] == 0) ? fmm_pkg::FP_DEFAULT_NAN : {s, 8'hFF, 23'd0};
         if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
         return round_pack(s, exp_of(a) + exp_of(b) - 300, frac_of(a) * frac_of(b));
      endfunction

      // The accumulated sum is the first operand, the product the second.
      function logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
         logic [31:0] big_op, small_op;
         longint unsigned big_sig, small_sig, sig;
         int d, scale;
         if (is_nan(a)) return a | fmm_pkg::FP_QUIET_BIT;
         if (is_nan(b)) return b | fmm_pkg::FP_QUIET_BIT;
         if (is_inf(a) && is_inf(b) && a[31] != b[31]) return fmm_pkg::FP_DEFAULT_NAN;
         if (is_inf(a)) return a;
         if (is_inf(b)) return b;
         if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
         if (a[30:0] == 0) return b;
         if (b[30:0] == 0) return a;
         if (a[30:0] >= b[30:0]) begin
            big_op = a;
            small_op = b;
         end else begin
            big_op = b;
            small_op = a;
         end
         d = exp_of(big_op) - exp_of(small_op);
         // A far smaller operand only matters as a sticky bit.
         if (d > 30) begin
            big_sig = frac_of(big_op) << 30;
            small_sig = 1;
            scale = exp_of(big_op) - 180;
         end else begin
            big_sig = frac_of(big_op) << d;
            small_sig = frac_of(small_op);
            scale = exp_of(big_op) - 150 - d;
         end
         if (big_op[31] == small_op[31]) sig = big_sig + small_sig;
         else sig = big_sig - small_sig;
         if (sig == 0) return fmm_pkg::FP_ZERO;
         return round_pack(big_op[31], scale, sig);
      endfunction

      // Notes one accepted input item and queues its expected result, if any.
      function void note_item(fmm_pkg::opcode_type op, logic [5:0] r, logic [5:0] c,
                              logic [31:0] bits);
         int unsigned nr, nk, nc;
         dot_result_type res;
         logic [31:0] acc;
         nr = eff(row_cnt);
         nk = eff(inner_cnt);
         nc = eff(col_cnt);
         case (op)
            fmm_pkg::OP_LOAD_FIRST: begin
               if (r < nr && c < nk) first_mem[r * 64 + c] = bits;
            end
            fmm_pkg::OP_LOAD_SECOND: begin
               if (r < nk && c < nc) second_mem[r * 64 + c] = bits;
            end
            fmm_pkg::OP_COMPUTE: begin
               res.row = r;
               res.col = c;
               res.bits = fmm_pkg::FP_ZERO;
               res.status = fmm_pkg::STATUS_RANGE;
               if (r < nr && c < nc) begin
                  acc = fmm_pkg::FP_ZERO;
                  for (int k = 0; k < nk; k++)
                     acc = fp_add(acc, fp_mul(first_mem[r * 64 + k], second_mem[k * 64 + c]));
                  res.bits = acc;
                  res.status = fmm_pkg::STATUS_OK;
               end
               pending_dots.push_back(res);
            end
            default: ;
         endcase
      endfunction

      // Checks one result item against the oldest expectation.
      function void check_result(logic [31:0] bits, logic [5:0] r, logic [5:0] c,
                                 logic st);
         dot_result_type want;
         if (pending_dots.size() == 0) begin
            $error("unexpected result item: bits %h row %0d col %0d", bits, r, c);
            errors++;
            return;
         end
         want = pending_dots.pop_front();
         if (bits !== want.bits) begin
            $error("result_bits: expected %h, actual %h", want.bits, bits);
            errors++;
         end
         if (r !== want.row) begin
            $error("result_row: expected %0d, actual %0d", want.row, r);
            errors++;
         end
         if (c !== want.col) begin
            $error("result_col: expected %0d, actual %0d", want.col, c);
            errors++;
         end
         if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = fmm_pkg::OP_UNUSED;
   logic [5:0]  req_row_index = '0;
   logic [5:0]  req_col_index = '0;
   logic [31:0] req_element_bits = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_result_bits;
   logic [5:0]  rsp_result_row;
   logic [5:0]  rsp_result_col;
   logic        rsp_status;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   matmul_scoreboard_type dot_board = new();
   int burst_left = 0;

   float_matrix_multiply_unit u_top (.*);

   always #5 clock = ~clock;

   // Results cannot be held off, so every strobe is checked at once.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         dot_board.check_result(rsp_result_bits, rsp_result_row, rsp_result_col, rsp_status);
   end

   // Drives one item and waits until the unit accepts it; most bursts end in a random gap.
   task automatic send_item(fmm_pkg::opcode_type op, logic [5:0] r, logic [5:0] c,
                            logic [31:0] bits);
      @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_row_index = r;
      req_col_index = c;
      req_element_bits = bits;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      dot_board.note_item(op, r, c, bits);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Holds off until every expected result has come and the unit is idle.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (dot_board.pending_dots.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_size(logic [1:0] idx, int unsigned value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      dot_board.set_size(idx, value);
   endtask

   task automatic set_sizes(int unsigned rows, int unsigned inner, int unsigned cols);
      drain();
      write_size(fmm_pkg::REG_ROW_COUNT, rows);
      write_size(fmm_pkg::REG_INNER_SIZE, inner);
      write_size(fmm_pkg::REG_COLUMN_COUNT, cols);
   endtask

   // Mostly moderate floats so sums stay meaningful, with raw patterns mixed in.
   function automatic logic [31:0] pick_float();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom())};
         default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 136)),
                          23'($urandom())};
      endcase
   endfunction

   function automatic logic [5:0] pick_index(int unsigned n);
      if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom());
      return 6'($urandom_range(0, n - 1));
   endfunction

   // Sets the sizes, fills both matrices in range, then sends a random mix.
   task automatic run_phase(int unsigned rows, int unsigned inner, int unsigned cols,
                            int count);
      int unsigned nr, nk, nc;
      int pick;
      set_sizes(rows, inner, cols);
      nr = dot_board.eff(rows & 32'h7F);
      nk = dot_board.eff(inner & 32'h7F);
      nc = dot_board.eff(cols & 32'h7F);
      for (int i = 0; i < nr; i++)
         for (int k = 0; k < nk; k++)
            send_item(fmm_pkg::OP_LOAD_FIRST, 6'(i), 6'(k), pick_float());
      for (int k = 0; k < nk; k++)
         for (int j = 0; j < nc; j++)
            send_item(fmm_pkg::OP_LOAD_SECOND, 6'(k), 6'(j), pick_float());
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            send_item(fmm_pkg::OP_LOAD_FIRST, pick_index(nr), pick_index(nk), pick_float());
         else if (pick < 60)
            send_item(fmm_pkg::OP_LOAD_SECOND, pick_index(nk), pick_index(nc), pick_float());
         else if (pick < 95)
            send_item(fmm_pkg::OP_COMPUTE, pick_index(nr), pick_index(nc), $urandom());
         else
            send_item(fmm_pkg::OP_UNUSED, 6'($urandom()), 6'($urandom()), $urandom());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: special values in a 2x2 by 2x2 product.
      set_sizes(2, 2, 2);
      send_item(fmm_pkg::OP_LOAD_FIRST, 6'd0, 6'd0, 32'h7F80_0000);
      send_item(fmm_pkg::OP_LOAD_FIRST, 6'd0, 6'd1, 32'hFFFF_FFFF);
      send_item(fmm_pkg::OP_LOAD_FIRST, 6'd1, 6'd0, 32'h7F7F_FFFF);
      send_item(fmm_pkg::OP_LOAD_FIRST, 6'd1, 6'd1, 32'h0000_0001);
      send_item(fmm_pkg::OP_LOAD_SECOND, 6'd0, 6'd0, fmm_pkg::FP_ZERO);
      send_item(fmm_pkg::OP_LOAD_SECOND, 6'd0, 6'd1, 32'h4000_0000);
      send_item(fmm_pkg::OP_LOAD_SECOND, 6'd1, 6'd0, 32'h8000_0000);
      send_item(fmm_pkg::OP_LOAD_SECOND, 6'd1, 6'd1, 32'h3F00_0000);
      send_item(fmm_pkg::OP_LOAD_FIRST, 6'd63, 6'd63, 32'h1234_5678);
      send_item(fmm_pkg::OP_LOAD_SECOND, 6'd0, 6'd63, 32'h1234_5678);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            send_item(fmm_pkg::OP_COMPUTE, 6'(i), 6'(j), 32'hFFFF_FFFF);
      send_item(fmm_pkg::OP_COMPUTE, 6'd63, 6'd63, fmm_pkg::FP_ZERO);
      send_item(fmm_pkg::OP_COMPUTE, 6'd0, 6'd2, fmm_pkg::FP_ZERO);
      send_item(fmm_pkg::OP_UNUSED, 6'd0, 6'd0, 32'h3F80_0000);
      // Overflow to infinity, then an infinite difference.
      send_item(fmm_pkg::OP_LOAD_FIRST, 6'd1, 6'd0, 32'h7F7F_FFFF);
      send_item(fmm_pkg::OP_LOAD_SECOND, 6'd0, 6'd0, 32'h7F7F_FFFF);
      send_item(fmm_pkg::OP_LOAD_FIRST, 6'd1, 6'd1, 32'hFF80_0000);
      send_item(fmm_pkg::OP_LOAD_SECOND, 6'd1, 6'd0, 32'h3F80_0000);
      send_item(fmm_pkg::OP_COMPUTE, 6'd1, 6'd0, fmm_pkg::FP_ZERO);

      // Let every result arrive before the random part.
      drain();

      run_phase(5, 3, 4, 60);
      run_phase(3, 0, 3, 20);
      run_phase(0, 4, 2, 20);
      run_phase(1, 64, 1, 20);
      run_phase(127, 1, 127, 30);
      run_phase(8, 16, 6, 60);
      run_phase(2, 5, 64, 30);
      run_phase(6, 7, 0, 20);
      run_phase(1, 1, 1, 30);
      run_phase(64, 2, 3, 60);

      drain();
      repeat (20) @(posedge clock);
      if (dot_board.errors == 0 && dot_board.pending_dots.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("status: fail");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/fmm_pkg.sv
design/fmm_ctrl.sv
design/fmm_datapath.sv
design/float_matrix_multiply_unit.sv
tb/sv/float_matrix_multiply_unit_tb.sv
